>>> sv/sq_pkg.sv
// Shared types, constants and helpers of the store-to-load forwarding queue.
`timescale 1ns / 1ps
`default_nettype none
package sq_pkg;
    localparam int QUEUE_DEPTH = 16;
    localparam int BLOCK_BYTES = 16;
    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int BLK_W = 44;
    localparam int DATA_W = 8 * BLOCK_BYTES;

    typedef enum logic [2:0] {
        OP_ALLOC   = 3'd0,
        OP_DATA    = 3'd1,
        OP_ANNUL   = 3'd2,
        OP_RELEASE = 3'd3,
        OP_SNOOP   = 3'd4,
        OP_MERGE   = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        ST_DONE    = 3'd0,
        ST_NOMATCH = 3'd1,
        ST_FORWARD = 3'd2,
        ST_PENDING = 3'd3,
        ST_PARTIAL = 3'd4,
        ST_ERROR   = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FIN
    } t_state;

    typedef struct packed {
        logic alloc;
        logic wdata;
        logic annul;
        logic release_e;
        logic tok_load;
        logic tok_shift;
    } t_cell_ctl;

    typedef struct packed {
        logic              valid;
        logic              annulled;
        logic              has_data;
        logic [BLK_W-1:0]  blk;
        logic [3:0]        off;
        logic [4:0]        size;
        logic [DATA_W-1:0] data;
    } t_cell_rd;

    // Byte mask of an access within the block.
    function automatic logic [BLOCK_BYTES-1:0] byte_mask(input logic [3:0] off,
                                                         input logic [4:0] size);
        logic [31:0] m;
        m = ((32'd1 << size) - 32'd1) << off;
        return m[BLOCK_BYTES-1:0];
    endfunction

    // Widen a byte mask to a bit mask.
    function automatic logic [DATA_W-1:0] expand(input logic [BLOCK_BYTES-1:0] m);
        logic [DATA_W-1:0] r;
        r = '0;
        for (int j = 0; j < BLOCK_BYTES; j++) begin
            r[8*j +: 8] = {8{m[j]}};
        end
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] size_bits(input logic [4:0] size);
        return expand(byte_mask(4'd0, size));
    endfunction

    function automatic logic access_ok(input logic [3:0] off, input logic [4:0] size);
        logic [5:0] e;
        e = {2'b00, off} + {1'b0, size};
        return ((size == 5'd1) || (size == 5'd2) || (size == 5'd4) || (size == 5'd8) ||
                (size == 5'd16)) && (e <= 6'(BLOCK_BYTES));
    endfunction
endpackage
`default_nettype wire

>>> sv/sq_cell.sv
// One store queue entry: its fields, its status bits and the walk token.
`timescale 1ns / 1ps
`default_nettype none
module sq_cell (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire sq_pkg::t_cell_ctl           i_ctl,
    input  wire logic                        i_start,
    input  wire logic                        i_tok,
    input  wire logic [sq_pkg::BLK_W-1:0]    i_blk,
    input  wire logic [3:0]                  i_off,
    input  wire logic [4:0]                  i_size,
    input  wire logic [sq_pkg::DATA_W-1:0]   i_data,
    output logic                             o_tok,
    output logic                             o_valid,
    output sq_pkg::t_cell_rd                 o_rd
);
    logic                      r_valid;
    logic                      r_annul;
    logic                      r_has;
    logic                      r_tok;
    logic [sq_pkg::BLK_W-1:0]  r_blk;
    logic [3:0]                r_off;
    logic [4:0]                r_size;
    logic [sq_pkg::DATA_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_annul <= 1'b0;
            r_has   <= 1'b0;
            r_tok   <= 1'b0;
        end else begin
            if (i_ctl.alloc) begin
                r_valid <= 1'b1;
                r_annul <= 1'b0;
                r_has   <= 1'b0;
            end else if (i_ctl.release_e) begin
                r_valid <= 1'b0;
                r_annul <= 1'b0;
                r_has   <= 1'b0;
            end else begin
                if (i_ctl.wdata) r_has <= 1'b1;
                if (i_ctl.annul) r_annul <= 1'b1;
            end
            if (i_ctl.tok_load) begin
                r_tok <= i_start;
            end else if (i_ctl.tok_shift) begin
                r_tok <= i_tok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.alloc) begin
            r_blk  <= i_blk;
            r_off  <= i_off;
            r_size <= i_size;
            r_data <= '0;
        end else if (i_ctl.wdata) begin
            r_data <= i_data & sq_pkg::size_bits(r_size);
        end
    end

    // Drive the shared read bus only while holding the token.
    always_comb begin
        o_rd.valid    = r_valid & r_tok;
        o_rd.annulled = r_annul & r_tok;
        o_rd.has_data = r_has & r_tok;
        o_rd.blk      = r_blk & {sq_pkg::BLK_W{r_tok}};
        o_rd.off      = r_off & {4{r_tok}};
        o_rd.size     = r_size & {5{r_tok}};
        o_rd.data     = r_data & {sq_pkg::DATA_W{r_tok}};
    end

    assign o_tok   = r_tok;
    assign o_valid = r_valid;
endmodule
`default_nettype wire

>>> sv/store_to_load_forwarding.sv
// Top level of the store queue with store-to-load forwarding.
// Usage: one input channel (i_in_valid / o_in_stall) carries one operation per
// transaction: allocate, store data, annul, release oldest, load snoop or load
// merge. Every input transaction gives exactly one output transaction on
// o_out_valid / i_out_stall with status, result value, slot and hit flag.
// Allocate, data, annul, release and all errors need no walk: the result is
// in the output register the cycle after acceptance.
// Snoop and merge walk the older stores oldest first: a token passes along
// the row of entry cells, one entry per cycle. One item is in work at a time.
// Reset (synchronous, active low) empties the queue, clears both pointers and
// the count, and drops any pending output. While the receiver stalls, the
// output register holds its result; no further transaction may enter, and a
// finished walk waits in place until the register frees.
`timescale 1ns / 1ps
`default_nettype none
module store_to_load_forwarding (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic [2:0]    i_operation,
    input  wire logic [43:0]   i_block_address,
    input  wire logic [3:0]    i_byte_offset,
    input  wire logic [4:0]    i_access_size,
    input  wire logic [3:0]    i_store_slot,
    input  wire logic [63:0]   i_data_low,
    input  wire logic [63:0]   i_data_high,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output logic [2:0]         o_status,
    output logic [63:0]        o_result_low,
    output logic [63:0]        o_result_high,
    output logic [3:0]         o_slot_out,
    output logic               o_forward_hit
);
    localparam int QD = sq_pkg::QUEUE_DEPTH;
    localparam int IW = sq_pkg::IDX_W;
    localparam int CW = sq_pkg::CNT_W;
    localparam int DW = sq_pkg::DATA_W;
    localparam int NB = sq_pkg::BLOCK_BYTES;

    sq_pkg::t_state r_state, n_state;
    logic [IW-1:0] r_head, n_head, r_tail, n_tail, r_idx, n_idx;
    logic [CW-1:0] r_count, n_count, r_rem, n_rem;

    // Load being walked.
    logic                     r_merge, n_merge;
    logic [sq_pkg::BLK_W-1:0] r_blk, n_blk;
    logic [3:0]               r_off, n_off;
    logic [4:0]               r_size, n_size;
    logic [DW-1:0]            r_acc, n_acc;
    logic                     r_found, n_found;
    logic                     r_partial, n_partial;
    logic                     r_pending, n_pending;
    logic [IW-1:0]            r_hslot, n_hslot;

    // Output register.
    logic          r_ovalid, n_ovalid;
    logic [2:0]    r_status, n_status;
    logic [DW-1:0] r_result, n_result;
    logic [3:0]    r_slot, n_slot;
    logic          r_hit, n_hit;

    sq_pkg::t_cell_ctl w_ctl [QD];
    sq_pkg::t_cell_rd  w_rd  [QD];
    sq_pkg::t_cell_rd  w_bus;
    logic [QD-1:0]     w_tok, w_valid;
    logic [DW-1:0]     w_indata;

    logic w_accept, w_free;
    logic w_alloc, w_wdata, w_annul, w_release, w_start;

    assign w_indata   = {i_data_high, i_data_low};
    assign w_free     = !r_ovalid || !i_out_stall;
    assign o_in_stall = (r_state != sq_pkg::S_IDLE) || !w_free;
    assign w_accept   = i_in_valid && !o_in_stall;

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p);
        return (p == IW'(QD - 1)) ? '0 : p + 1'b1;
    endfunction

    // Row of entry cells; the token hands on to the next cell in ring order.
    for (genvar g = 0; g < QD; g++) begin : g_cell
        always_comb begin
            w_ctl[g].alloc     = w_alloc && (r_tail == IW'(g));
            w_ctl[g].wdata     = w_wdata && (i_store_slot[IW-1:0] == IW'(g));
            w_ctl[g].annul     = w_annul && (i_store_slot[IW-1:0] == IW'(g));
            w_ctl[g].release_e = w_release && (r_head == IW'(g));
            w_ctl[g].tok_load  = w_start;
            w_ctl[g].tok_shift = (r_state == sq_pkg::S_WALK);
        end
        sq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[g]),
            .i_start (r_head == IW'(g)),
            .i_tok   (w_tok[(g + QD - 1) % QD]),
            .i_blk   (i_block_address),
            .i_off   (i_byte_offset),
            .i_size  (i_access_size),
            .i_data  (w_indata),
            .o_tok   (w_tok[g]),
            .o_valid (w_valid[g]),
            .o_rd    (w_rd[g])
        );
    end

    always_comb begin
        w_bus = '0;
        for (int i = 0; i < QD; i++) begin
            w_bus = w_bus | w_rd[i];
        end
    end

    // Walk step on the entry holding the token.
    logic [NB-1:0] w_smask, w_lmask, w_lframe;
    logic [DW-1:0] w_image, w_loadv, w_fbits;
    logic          w_elig;
    always_comb begin
        w_smask  = sq_pkg::byte_mask(w_bus.off, w_bus.size);
        w_lmask  = sq_pkg::byte_mask(r_off, r_size);
        w_lframe = (w_smask >> r_off) & sq_pkg::byte_mask(4'd0, r_size);
        w_image  = w_bus.data << {w_bus.off, 3'b000};
        w_loadv  = w_image >> {r_off, 3'b000};
        w_fbits  = sq_pkg::expand(w_lframe);
        w_elig   = w_bus.valid && !w_bus.annulled && (w_bus.blk == r_blk);
    end

    logic [4:0]    w_sl5;
    logic [IW-1:0] w_sl;
    logic [CW-1:0] w_older;
    logic          w_older_ok, w_aok;
    always_comb begin
        w_sl5 = {1'b0, i_store_slot};
        w_sl  = i_store_slot[IW-1:0];
        w_aok = sq_pkg::access_ok(i_byte_offset, i_access_size);
        if (w_sl == r_tail) begin
            w_older = r_count;
        end else if (w_sl >= r_head) begin
            w_older = CW'(w_sl - r_head);
        end else begin
            w_older = CW'({1'b0, w_sl} + (IW + 1)'(QD) - {1'b0, r_head});
        end
        w_older_ok = (w_sl5 < 5'(QD)) && (w_older <= r_count);
    end

    always_comb begin
        n_state = r_state; n_head = r_head; n_tail = r_tail; n_idx = r_idx;
        n_count = r_count; n_rem = r_rem;
        n_merge = r_merge; n_blk = r_blk; n_off = r_off; n_size = r_size;
        n_acc = r_acc; n_found = r_found; n_partial = r_partial;
        n_pending = r_pending; n_hslot = r_hslot;
        n_ovalid = r_ovalid && i_out_stall;
        n_status = r_status; n_result = r_result; n_slot = r_slot; n_hit = r_hit;
        w_alloc = 1'b0; w_wdata = 1'b0; w_annul = 1'b0; w_release = 1'b0;
        w_start = 1'b0;
        unique case (r_state)
            sq_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_ovalid = 1'b1;
                    n_status = sq_pkg::ST_ERROR;
                    n_result = '0;
                    n_slot   = '0;
                    n_hit    = 1'b0;
                    unique case (i_operation)
                        sq_pkg::OP_ALLOC: begin
                            if (w_aok && (r_count != CW'(QD))) begin
                                w_alloc  = 1'b1;
                                n_slot   = 4'(r_tail);
                                n_tail   = wrap_inc(r_tail);
                                n_count  = r_count + 1'b1;
                                n_status = sq_pkg::ST_DONE;
                            end
                        end
                        sq_pkg::OP_DATA, sq_pkg::OP_ANNUL: begin
                            if ((w_sl5 < 5'(QD)) && w_valid[w_sl]) begin
                                w_wdata  = (i_operation == sq_pkg::OP_DATA);
                                w_annul  = (i_operation == sq_pkg::OP_ANNUL);
                                n_slot   = i_store_slot;
                                n_status = sq_pkg::ST_DONE;
                            end
                        end
                        sq_pkg::OP_RELEASE: begin
                            if (r_count != '0) begin
                                w_release = 1'b1;
                                n_slot    = 4'(r_head);
                                n_head    = wrap_inc(r_head);
                                n_count   = r_count - 1'b1;
                                n_status  = sq_pkg::ST_DONE;
                            end
                        end
                        sq_pkg::OP_SNOOP, sq_pkg::OP_MERGE: begin
                            if (w_aok && w_older_ok) begin
                                // Hold the result back until the walk ends.
                                n_ovalid  = r_ovalid && i_out_stall;
                                n_status  = r_status;
                                n_result  = r_result;
                                n_slot    = r_slot;
                                n_hit     = r_hit;
                                w_start   = 1'b1;
                                n_merge   = (i_operation == sq_pkg::OP_MERGE);
                                n_blk     = i_block_address;
                                n_off     = i_byte_offset;
                                n_size    = i_access_size;
                                n_acc     = w_indata & sq_pkg::size_bits(i_access_size);
                                n_found   = 1'b0;
                                n_partial = 1'b0;
                                n_pending = 1'b0;
                                n_hslot   = '0;
                                n_idx     = r_head;
                                n_rem     = w_older;
                                n_state   = (w_older == '0) ? sq_pkg::S_FIN
                                                            : sq_pkg::S_WALK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            sq_pkg::S_WALK: begin
                if (r_merge) begin
                    if (w_elig && w_bus.has_data) begin
                        n_acc = (r_acc & ~w_fbits) | (w_loadv & w_fbits);
                    end
                end else if (w_elig && ((w_smask & w_lmask) != '0)) begin
                    // Younger matches override older ones.
                    n_found   = 1'b1;
                    n_hslot   = r_idx;
                    n_partial = ((w_smask & w_lmask) != w_lmask);
                    n_pending = !w_bus.has_data;
                    n_acc     = w_loadv & sq_pkg::size_bits(r_size);
                end
                n_idx = wrap_inc(r_idx);
                n_rem = r_rem - 1'b1;
                if (r_rem == CW'(1)) n_state = sq_pkg::S_FIN;
            end
            sq_pkg::S_FIN: begin
                if (w_free) begin
                    n_ovalid = 1'b1;
                    n_state  = sq_pkg::S_IDLE;
                    n_result = '0;
                    n_slot   = '0;
                    n_hit    = 1'b0;
                    priority if (r_merge) begin
                        n_status = sq_pkg::ST_DONE;
                        n_result = r_acc;
                    end else if (!r_found) begin
                        n_status = sq_pkg::ST_NOMATCH;
                    end else if (r_partial) begin
                        n_status = sq_pkg::ST_PARTIAL;
                        n_slot   = 4'(r_hslot);
                    end else if (r_pending) begin
                        n_status = sq_pkg::ST_PENDING;
                        n_slot   = 4'(r_hslot);
                    end else begin
                        n_status = sq_pkg::ST_FORWARD;
                        n_slot   = 4'(r_hslot);
                        n_result = r_acc;
                        n_hit    = 1'b1;
                    end
                end
            end
            default: n_state = sq_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sq_pkg::S_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_rem    <= '0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_rem    <= n_rem;
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_merge   <= n_merge;
        r_blk     <= n_blk;
        r_off     <= n_off;
        r_size    <= n_size;
        r_acc     <= n_acc;
        r_found   <= n_found;
        r_partial <= n_partial;
        r_pending <= n_pending;
        r_hslot   <= n_hslot;
        r_status  <= n_status;
        r_result  <= n_result;
        r_slot    <= n_slot;
        r_hit     <= n_hit;
    end

    assign o_out_valid   = r_ovalid;
    assign o_status      = r_status;
    assign o_result_low  = r_result[63:0];
    assign o_result_high = r_result[127:64];
    assign o_slot_out    = r_slot;
    assign o_forward_hit = r_hit;

    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == 32'(r_count))
        else $error("entry count differs from number of valid cells");

    a_one_token_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sq_pkg::S_WALK) |-> $onehot(w_tok))
        else $error("walk token lost or duplicated");

    a_hit_only_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_hit) |-> (r_status == sq_pkg::ST_FORWARD))
        else $error("forward hit without forwarded status");

    a_walk_token_at_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sq_pkg::S_WALK) |-> w_tok[r_idx])
        else $error("walk index and token disagree");
endmodule
`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the store queue with store-to-load forwarding.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_stall;
    logic [2:0]    i_operation;
    logic [43:0]   i_block_address;
    logic [3:0]    i_byte_offset;
    logic [4:0]    i_access_size;
    logic [3:0]    i_store_slot;
    logic [63:0]   i_data_low;
    logic [63:0]   i_data_high;
    logic          o_out_valid;
    logic          i_out_stall;
    logic [2:0]    o_status;
    logic [63:0]   o_result_low;
    logic [63:0]   o_result_high;
    logic [3:0]    o_slot_out;
    logic          o_forward_hit;

    store_to_load_forwarding dut (.*);

    // One expected output transaction.
    typedef struct {
        logic [2:0]   status;
        logic [127:0] value;
        logic [3:0]   slot;
        logic         hit;
    } t_outcome;

    // Shadow copy of the queue.
    logic         q_valid  [sq_pkg::QUEUE_DEPTH];
    logic         q_annul  [sq_pkg::QUEUE_DEPTH];
    logic         q_hasdat [sq_pkg::QUEUE_DEPTH];
    logic [43:0]  q_blk    [sq_pkg::QUEUE_DEPTH];
    logic [3:0]   q_off    [sq_pkg::QUEUE_DEPTH];
    logic [4:0]   q_size   [sq_pkg::QUEUE_DEPTH];
    logic [127:0] q_data   [sq_pkg::QUEUE_DEPTH];
    int           q_head, q_tail, q_count;

    t_outcome pending_outcomes[$];
    int       mismatches;
    int       results_seen;
    int       send_idle_pct, stall_pct;
    bit       hold_off;
    int       hold_cycles;
    int       status_hits[6];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic bit legal_access(logic [3:0] off, logic [4:0] size);
        return (size == 1 || size == 2 || size == 4 || size == 8 || size == 16) &&
               (int'(off) + int'(size) <= sq_pkg::BLOCK_BYTES);
    endfunction

    function automatic logic [15:0] bytes_of(logic [3:0] off, logic [4:0] size);
        logic [31:0] m;
        m = ((32'd1 << size) - 32'd1) << off;
        return m[15:0];
    endfunction

    function automatic logic [127:0] keep_bytes(logic [127:0] v, logic [4:0] size);
        logic [127:0] r;
        r = '0;
        for (int j = 0; j < 16; j++)
            if (j < size) r[8*j +: 8] = v[8*j +: 8];
        return r;
    endfunction

    // Compute the outcome of one operation and advance the shadow queue.
    function automatic t_outcome queue_predict(logic [2:0] op, logic [43:0] blk,
            logic [3:0] off, logic [4:0] size, logic [3:0] slot, logic [127:0] dat);
        t_outcome o;
        int n, e, b;
        bit ok;
        logic [15:0] lm, sm;
        o.status = sq_pkg::ST_ERROR; o.value = '0; o.slot = '0; o.hit = 1'b0;
        ok = 1'b0; n = 0;
        if (op == sq_pkg::OP_SNOOP || op == sq_pkg::OP_MERGE) begin
            if (int'(slot) == q_tail) begin
                n = q_count; ok = 1'b1;
            end else begin
                n = (int'(slot) + sq_pkg::QUEUE_DEPTH - q_head) % sq_pkg::QUEUE_DEPTH;
                ok = (n <= q_count);
            end
            ok = ok && legal_access(off, size);
        end
        case (op)
            sq_pkg::OP_ALLOC: if (legal_access(off, size) &&
                                  q_count < sq_pkg::QUEUE_DEPTH) begin
                q_valid[q_tail] = 1'b1; q_annul[q_tail] = 1'b0; q_hasdat[q_tail] = 1'b0;
                q_blk[q_tail] = blk; q_off[q_tail] = off; q_size[q_tail] = size;
                q_data[q_tail] = '0;
                o.slot = 4'(q_tail); o.status = sq_pkg::ST_DONE;
                q_tail = (q_tail + 1) % sq_pkg::QUEUE_DEPTH; q_count++;
            end
            sq_pkg::OP_DATA, sq_pkg::OP_ANNUL: if (q_valid[slot]) begin
                if (op == sq_pkg::OP_DATA) begin
                    q_data[slot] = keep_bytes(dat, q_size[slot]);
                    q_hasdat[slot] = 1'b1;
                end else begin
                    q_annul[slot] = 1'b1;
                end
                o.slot = slot; o.status = sq_pkg::ST_DONE;
            end
            sq_pkg::OP_RELEASE: if (q_count > 0) begin
                q_valid[q_head] = 1'b0; q_annul[q_head] = 1'b0; q_hasdat[q_head] = 1'b0;
                o.slot = 4'(q_head); o.status = sq_pkg::ST_DONE;
                q_head = (q_head + 1) % sq_pkg::QUEUE_DEPTH; q_count--;
            end
            sq_pkg::OP_SNOOP: if (ok) begin
                lm = bytes_of(off, size);
                o.status = sq_pkg::ST_NOMATCH;
                for (int k = n; k > 0; k--) begin
                    e = (q_head + k - 1) % sq_pkg::QUEUE_DEPTH;
                    if (!q_valid[e] || q_annul[e] || q_blk[e] != blk) continue;
                    sm = bytes_of(q_off[e], q_size[e]);
                    if ((sm & lm) == 0) continue;
                    o.slot = 4'(e);
                    if ((sm & lm) != lm) o.status = sq_pkg::ST_PARTIAL;
                    else if (!q_hasdat[e]) o.status = sq_pkg::ST_PENDING;
                    else begin
                        for (int j = 0; j < size; j++)
                            o.value[8*j +: 8] =
                                q_data[e][8*((off + j - q_off[e]) & 15) +: 8];
                        o.status = sq_pkg::ST_FORWARD; o.hit = 1'b1;
                    end
                    break;
                end
            end
            sq_pkg::OP_MERGE: if (ok) begin
                o.value = keep_bytes(dat, size);
                for (int k = 0; k < n; k++) begin
                    e = (q_head + k) % sq_pkg::QUEUE_DEPTH;
                    if (!q_valid[e] || q_annul[e] || !q_hasdat[e] || q_blk[e] != blk)
                        continue;
                    sm = bytes_of(q_off[e], q_size[e]);
                    for (int j = 0; j < size; j++) begin
                        b = off + j;
                        if (sm[b])
                            o.value[8*j +: 8] = q_data[e][8*((b - q_off[e]) & 15) +: 8];
                    end
                end
                o.status = sq_pkg::ST_DONE;
            end
            default: ;
        endcase
        return o;
    endfunction

    // Offer one transaction, predict it on acceptance.
    task automatic send_op(logic [2:0] op, logic [43:0] blk, logic [3:0] off,
                           logic [4:0] size, logic [3:0] slot, logic [127:0] dat);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct)
            @(negedge i_clk);
        i_in_valid = 1'b1; i_operation = op; i_block_address = blk;
        i_byte_offset = off; i_access_size = size; i_store_slot = slot;
        i_data_low = dat[63:0]; i_data_high = dat[127:64];
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_outcomes.push_back(queue_predict(op, blk, off, size, slot, dat));
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // Receiver stall, set at the falling edge.
    always @(negedge i_clk) begin
        if (hold_off) begin
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= (stall_pct > 0) && ($urandom_range(99, 0) < stall_pct);
        end
    end

    // Count the long hold-off in its own process.
    always @(posedge i_clk) begin
        if (hold_off) begin
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles >= 120) hold_off <= 1'b0;
        end
    end

    // Compare each output transaction with the oldest expectation.
    always @(posedge i_clk) begin
        t_outcome x;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result status %0d", o_status);
            end else begin
                x = pending_outcomes.pop_front();
                if (o_status < 6) status_hits[o_status]++;
                if (o_status !== x.status || {o_result_high, o_result_low} !== x.value ||
                    o_slot_out !== x.slot || o_forward_hit !== x.hit) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp st=%0d v=%h s=%0d h=%0d",
                                  " got st=%0d v=%h s=%0d h=%0d"},
                                 x.status, x.value, x.slot, x.hit, o_status,
                                 {o_result_high, o_result_low}, o_slot_out, o_forward_hit);
                end
            end
        end
    end

    function automatic logic [4:0] pick_size();
        case ($urandom_range(4, 0))
            0: return 5'd1;
            1: return 5'd2;
            2: return 5'd4;
            3: return 5'd8;
            default: return 5'd16;
        endcase
    endfunction

    function automatic logic [127:0] rand_data();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    task automatic drain();
        while (pending_outcomes.size() != 0) @(negedge i_clk);
    endtask

    // Extremes of every field, each operation and many error cases.
    task automatic test_directed();
        logic [43:0] top;
        top = '1;
        // release on empty queue
        send_op(sq_pkg::OP_RELEASE, 44'd0, 4'd0, 5'd1, 4'd0, 128'd0);
        // data to a slot never allocated
        send_op(sq_pkg::OP_DATA, 44'd0, 4'd0, 5'd1, 4'd15, '1);
        send_op(sq_pkg::OP_ANNUL, 44'd0, 4'd0, 5'd1, 4'd3, 128'd0);
        // crosses the block
        send_op(sq_pkg::OP_ALLOC, top, 4'd15, 5'd2, 4'd0, 128'd0);
        // illegal size
        send_op(sq_pkg::OP_ALLOC, top, 4'd0, 5'd3, 4'd0, 128'd0);
        send_op(sq_pkg::OP_ALLOC, top, 4'd0, 5'd16, 4'd0, 128'd0);
        // covered, no data yet
        send_op(sq_pkg::OP_SNOOP, top, 4'd4, 5'd4, 4'd1, 128'd0);
        send_op(sq_pkg::OP_DATA, 44'd0, 4'd0, 5'd1, 4'd0, '1);
        // forward
        send_op(sq_pkg::OP_SNOOP, top, 4'd4, 5'd4, 4'd1, 128'd0);
        send_op(sq_pkg::OP_ALLOC, top, 4'd8, 5'd8, 4'd0, 128'd0);
        // partial
        send_op(sq_pkg::OP_SNOOP, top, 4'd0, 5'd16, 4'd2, 128'd0);
        send_op(sq_pkg::OP_MERGE, top, 4'd0, 5'd16, 4'd2,
                {64'h0123456789abcdef, 64'h0});
        send_op(sq_pkg::OP_ANNUL, 44'd0, 4'd0, 5'd1, 4'd1, 128'd0);
        // annul twice
        send_op(sq_pkg::OP_ANNUL, 44'd0, 4'd0, 5'd1, 4'd1, 128'd0);
        // data on annulled store
        send_op(sq_pkg::OP_DATA, 44'd0, 4'd0, 5'd1, 4'd1, rand_data());
        // nothing older
        send_op(sq_pkg::OP_SNOOP, top, 4'd15, 5'd1, 4'd0, 128'd0);
        // slot beyond the count
        send_op(sq_pkg::OP_SNOOP, top, 4'd0, 5'd1, 4'd9, 128'd0);
        send_op(3'd6, 44'd0, 4'd0, 5'd1, 4'd0, 128'd0);
        send_op(3'd7, top, 4'd15, 5'd31, 4'd15, '1);
        for (int i = 0; i < 15; i++)
            send_op(sq_pkg::OP_ALLOC, 44'd0, 4'd0, 5'd1, 4'd0, 128'd0);
        // full queue
        send_op(sq_pkg::OP_ALLOC, 44'd0, 4'd0, 5'd1, 4'd0, 128'd0);
        drain();
    endtask

    // Mostly well-formed traffic on a few blocks so stores and loads collide.
    task automatic test_random(int items);
        int r;
        logic [43:0] blk;
        logic [3:0]  off, slot;
        logic [4:0]  sz;
        logic [2:0]  op;
        for (int i = 0; i < items; i++) begin
            r = $urandom_range(99, 0);
            sz = pick_size();
            off = 4'($urandom_range(16 - int'(sz), 0) & ~(int'(sz) - 1));
            blk = ($urandom_range(9, 0) == 0) ? 44'({$urandom, $urandom})
                                              : 44'($urandom_range(2, 0));
            if ($urandom_range(29, 0) == 0) begin
                sz = 5'($urandom); off = 4'($urandom);
            end
            slot = (q_count == 0) ? 4'(q_tail)
                 : 4'((q_head + $urandom_range(q_count, 0)) % sq_pkg::QUEUE_DEPTH);
            if (r < 22) op = sq_pkg::OP_ALLOC;
            else if (r < 40) begin
                op = sq_pkg::OP_DATA;
                slot = 4'((q_head + $urandom_range(q_count == 0 ? 0 : q_count - 1, 0))
                          % sq_pkg::QUEUE_DEPTH);
            end else if (r < 45) op = sq_pkg::OP_ANNUL;
            else if (r < 62) op = sq_pkg::OP_RELEASE;
            else if (r < 82) op = sq_pkg::OP_SNOOP;
            else if (r < 97) op = sq_pkg::OP_MERGE;
            else begin
                op = 3'($urandom); slot = 4'($urandom);
            end
            if (op == sq_pkg::OP_ANNUL || op == sq_pkg::OP_DATA) begin
                if (q_count != 0 && !q_valid[slot]) slot = 4'(q_head);
                if (q_count == 0 && $urandom_range(1, 0)) slot = 4'($urandom);
            end
            send_op(op, blk, off, sz, slot, rand_data());
        end
    endtask

    // Keep the receiver off while the sender fills the block.
    task automatic test_backpressure();
        hold_cycles = 0;
        hold_off = 1'b1;
        test_random(20);
        drain();
        // no idling on either side, then wait until every result is back
        send_idle_pct = 0;
        stall_pct = 0;
        test_random(10);
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_out_stall = 1'b0;
        i_operation = '0; i_block_address = '0; i_byte_offset = '0;
        i_access_size = '0; i_store_slot = '0; i_data_low = '0; i_data_high = '0;
        mismatches = 0; results_seen = 0; hold_off = 1'b0; hold_cycles = 0;
        send_idle_pct = 0; stall_pct = 0;
        foreach (status_hits[i]) status_hits[i] = 0;
        foreach (q_valid[i]) begin
            q_valid[i] = 1'b0; q_annul[i] = 1'b0; q_hasdat[i] = 1'b0;
            q_blk[i] = '0; q_off[i] = '0; q_size[i] = '0; q_data[i] = '0;
        end
        q_head = 0; q_tail = 0; q_count = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        // idling phases: none, sender, receiver, both
        send_idle_pct = 0;  stall_pct = 0;  test_random(220);
        send_idle_pct = 73; stall_pct = 0;  test_random(220);
        send_idle_pct = 0;  stall_pct = 73; test_random(220);
        send_idle_pct = 24; stall_pct = 24; test_random(220);
        test_backpressure();
        drain();
        repeat (40) @(negedge i_clk);

        $display("ran %0d transactions: done %0d, no match %0d, forwarded %0d,",
                 results_seen, status_hits[0], status_hits[1], status_hits[2]);
        $display("  pending %0d, partial %0d, error %0d; %0d mismatches",
                 status_hits[3], status_hits[4], status_hits[5], mismatches);
        if (mismatches == 0 && pending_outcomes.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire

>>> store_to_load_forwarding.f
sv/sq_pkg.sv
sv/sq_cell.sv
sv/store_to_load_forwarding.sv
tb/tb.sv
